### rtl/core/prp_pkg.sv
// Shared types and constants for the partitioned Rice residual packer.
// Holds the word geometry, status and register codes, and the stage structs.
// Depends on nothing; every other file of the core refers to it by scoped names.
package prp_pkg;

  localparam int WORD_BITS   = 32;
  localparam int WORD_CNT_W  = 6;
  localparam int ACC_CNT_W   = 5;
  localparam int HEAD_BITS   = 26;
  localparam int HEAD_CNT_W  = 5;
  localparam int TAIL_BITS   = 32;
  localparam int TAIL_CNT_W  = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ORDER    = 2'd1,
    STATUS_ESCAPE   = 2'd2,
    STATUS_QUOTIENT = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WIDE_PARAM_MODE = 2'd0,
    CFG_PARTITION_ORDER = 2'd1,
    CFG_PREDICTOR_ORDER = 2'd2,
    CFG_BLOCK_SIZE      = 2'd3
  } cfg_index_t;

  // One coded sample: header bits, then a run of zeros carried alongside, then the tail.
  typedef struct packed {
    logic [HEAD_BITS-1:0]  head;
    logic [HEAD_CNT_W-1:0] head_len;
    logic [TAIL_BITS-1:0]  tail;
    logic [TAIL_CNT_W-1:0] tail_len;
    logic                  block_end;
    logic                  abort;
    status_t               status;
  } desc_t;

  // Up to one word of bits, right-aligned, for the packer.
  typedef struct packed {
    logic [WORD_BITS-1:0]  data;
    logic [WORD_CNT_W-1:0] len;
    logic                  block_end;
    logic                  abort;
    status_t               status;
  } chunk_t;

endpackage

### rtl/core/partitioned_rice_residual_packer_core.sv
// Top level of the partitioned Rice residual packer: front end, chunker and word packer.
// Depends on prp_pkg, prp_frontend, prp_chunker and prp_packer.
//
//   Channel   Handshake                 Payload
//   item      item_valid / item_stall   residual, rice_param, raw_escape
//   result    result_valid / result_stall  word, valid_bits, block_end, status
//   config    cfg_wr_en                 cfg_index, cfg_data
//
// One item is taken per cycle while its coded bits, partition headers included, fit in
// one 32-bit word and result_stall holds nothing back; a longer item occupies the chunker
// until every chunk of it is out. The last item of a block whose bits leave a partial word
// after a full one needs a separate flush result from the packer.
// Reset clears all control state and loads the register defaults; there is no clearing pass.
// A held result_stall fills the internal stages, after which item_stall rises.
module partitioned_rice_residual_packer_core #(
  parameter int MAX_QUOTIENT = 1023,
  localparam int QuotW = $clog2(MAX_QUOTIENT + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [prp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [prp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic signed [31:0]                 residual,
  input  logic [4:0]                         rice_param,
  input  logic                               raw_escape,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [prp_pkg::WORD_BITS-1:0]      word,
  output logic [prp_pkg::WORD_CNT_W-1:0]     valid_bits,
  output logic                               block_end,
  output logic [1:0]                         status
);

  logic               desc_valid;
  prp_pkg::desc_t     desc;
  logic [QuotW-1:0]   desc_zeros;
  logic               desc_ready;
  logic               chunk_valid;
  prp_pkg::chunk_t    chunk;
  logic               chunk_take;

  prp_frontend #(
    .MAX_QUOTIENT(MAX_QUOTIENT)
  ) u_frontend (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .residual   (residual),
    .rice_param (rice_param),
    .raw_escape (raw_escape),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_zeros (desc_zeros),
    .desc_ready (desc_ready)
  );

  prp_chunker #(
    .MAX_QUOTIENT(MAX_QUOTIENT)
  ) u_chunker (
    .clk         (clk),
    .rst         (rst),
    .desc_valid  (desc_valid),
    .desc        (desc),
    .desc_zeros  (desc_zeros),
    .desc_ready  (desc_ready),
    .chunk_valid (chunk_valid),
    .chunk       (chunk),
    .chunk_take  (chunk_take)
  );

  prp_packer u_packer (
    .clk          (clk),
    .rst          (rst),
    .chunk_valid  (chunk_valid),
    .chunk        (chunk),
    .chunk_take   (chunk_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .word         (word),
    .valid_bits   (valid_bits),
    .block_end    (block_end),
    .status       (status)
  );

endmodule

### rtl/core/prp_frontend.sv
// Input register, configuration registers and partition bookkeeping.
// Turns each sample into a coded description (headers, zero run, tail) for the chunker.
// Depends on prp_pkg.
module prp_frontend #(
  parameter int MAX_QUOTIENT = 1023,
  localparam int QuotW = $clog2(MAX_QUOTIENT + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [prp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [prp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic signed [31:0]                 residual,
  input  logic [4:0]                         rice_param,
  input  logic                               raw_escape,
  output logic                               desc_valid,
  output prp_pkg::desc_t                     desc,
  output logic [QuotW-1:0]                   desc_zeros,
  input  logic                               desc_ready
);

  logic        in_full;
  logic [31:0] residual_r;
  logic [4:0]  param_r;
  logic        raw_r;

  logic        wide_mode;
  logic [3:0]  part_order;
  logic [5:0]  pred_order;
  logic [15:0] blk_size;

  logic        header_sent;
  logic [15:0] part_index;
  logic [15:0] samples_left;
  logic [4:0]  latched_param;
  logic        latched_raw;

  logic        fire;
  logic [15:0] base;
  logic [15:0] pred_ext;
  logic [15:0] last_part;
  logic        order_bad;
  logic        opening;
  logic [4:0]  k;
  logic        raw_sel;
  logic [4:0]  esc;
  logic        escape_bad;
  logic [31:0] zig;
  logic [31:0] quot;
  logic        quot_bad;
  logic        aborting;
  prp_pkg::status_t abort_status;
  logic [3:0]  hdr_len;
  logic [9:0]  hdr_bits;
  logic [15:0] idx_open;
  logic [15:0] first_len;
  logic [15:0] len_open;
  logic        dbl;
  logic [15:0] idx_final;
  logic [15:0] len_fix;
  logic [15:0] left_open;
  logic [15:0] left_next;
  logic        blk_done;
  logic [prp_pkg::HEAD_BITS-1:0]  h1, h2, h3;
  logic [prp_pkg::HEAD_CNT_W-1:0] n1, n2, n3;
  logic [31:0] kmask;
  logic [31:0] tail;
  logic [prp_pkg::TAIL_CNT_W-1:0] tail_len;

  assign fire       = in_full && desc_ready;
  assign item_stall = in_full && !desc_ready;
  assign desc_valid = in_full;

  always_comb begin
    base      = blk_size >> part_order;
    pred_ext  = {10'd0, pred_order};
    last_part = ~(16'hFFFF << part_order);
    order_bad = !header_sent && ((base < pred_ext) || (16'(base << part_order) == pred_ext));
    opening   = !header_sent || (samples_left == 16'd0);
    k         = opening ? param_r : latched_param;
    raw_sel   = opening ? raw_r : latched_raw;
    esc       = wide_mode ? 5'd31 : 5'd15;
    escape_bad = opening && !raw_sel && (k >= esc);
    zig       = residual_r[31] ? {~residual_r[30:0], 1'b1} : {residual_r[30:0], 1'b0};
    quot      = zig >> k;
    quot_bad  = !raw_sel && (quot > 32'(MAX_QUOTIENT));
    aborting  = order_bad || escape_bad || quot_bad;
    if (order_bad) begin
      abort_status = prp_pkg::STATUS_ORDER;
    end else if (escape_bad) begin
      abort_status = prp_pkg::STATUS_ESCAPE;
    end else begin
      abort_status = prp_pkg::STATUS_QUOTIENT;
    end

    if (raw_r) begin
      hdr_len  = wide_mode ? 4'd10 : 4'd9;
      hdr_bits = wide_mode ? {5'h1F, param_r} : {1'b0, 4'hF, param_r};
    end else begin
      hdr_len  = wide_mode ? 4'd5 : 4'd4;
      hdr_bits = wide_mode ? {5'd0, param_r} : {6'd0, param_r[3:0]};
    end

    idx_open  = header_sent ? part_index + 16'd1 : 16'd0;
    first_len = (base > pred_ext) ? base - pred_ext : 16'd0;
    len_open  = (idx_open == 16'd0) ? first_len : base;
    dbl       = opening && (len_open == 16'd0) && (idx_open == 16'd0) && (part_order != 4'd0);
    idx_final = opening ? (dbl ? 16'd1 : idx_open) : part_index;
    len_fix   = dbl ? base : len_open;
    left_open = opening ? ((len_fix == 16'd0) ? 16'd1 : len_fix) : samples_left;
    left_next = left_open - 16'd1;
    blk_done  = (left_next == 16'd0) && (idx_final >= last_part);

    h1 = header_sent ? '0 : prp_pkg::HEAD_BITS'({1'b0, wide_mode, part_order});
    n1 = header_sent ? '0 : prp_pkg::HEAD_CNT_W'(6);
    h2 = opening ? ((h1 << hdr_len) | prp_pkg::HEAD_BITS'(hdr_bits)) : h1;
    n2 = opening ? n1 + prp_pkg::HEAD_CNT_W'(hdr_len) : n1;
    h3 = dbl ? ((h2 << hdr_len) | prp_pkg::HEAD_BITS'(hdr_bits)) : h2;
    n3 = dbl ? n2 + prp_pkg::HEAD_CNT_W'(hdr_len) : n2;

    kmask = ~(32'hFFFF_FFFF << k);
    if (raw_sel) begin
      tail     = residual_r & kmask;
      tail_len = prp_pkg::TAIL_CNT_W'(k);
    end else begin
      tail     = (32'd1 << k) | (zig & kmask);
      tail_len = prp_pkg::TAIL_CNT_W'(k) + prp_pkg::TAIL_CNT_W'(1);
    end

    desc.head      = aborting ? '0 : h3;
    desc.head_len  = aborting ? '0 : n3;
    desc.tail      = aborting ? '0 : tail;
    desc.tail_len  = aborting ? '0 : tail_len;
    desc.block_end = !aborting && blk_done;
    desc.abort     = aborting;
    desc.status    = aborting ? abort_status : prp_pkg::STATUS_OK;
    desc_zeros     = (aborting || raw_sel) ? '0 : quot[QuotW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full    <= 1'b0;
      wide_mode  <= 1'b0;
      part_order <= 4'd0;
      pred_order <= 6'd0;
      blk_size   <= 16'd4096;
    end else begin
      if (item_valid && !item_stall) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (prp_pkg::cfg_index_t'(cfg_index))
          prp_pkg::CFG_WIDE_PARAM_MODE: wide_mode  <= cfg_data[0];
          prp_pkg::CFG_PARTITION_ORDER: part_order <= cfg_data[3:0];
          prp_pkg::CFG_PREDICTOR_ORDER: pred_order <= cfg_data[5:0];
          prp_pkg::CFG_BLOCK_SIZE:      blk_size   <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      residual_r <= residual;
      param_r    <= rice_param;
      raw_r      <= raw_escape;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_sent   <= 1'b0;
      part_index    <= 16'd0;
      samples_left  <= 16'd0;
      latched_param <= 5'd0;
      latched_raw   <= 1'b0;
    end else if (fire) begin
      if (aborting || blk_done) begin
        header_sent  <= 1'b0;
        part_index   <= 16'd0;
        samples_left <= 16'd0;
      end else begin
        header_sent  <= 1'b1;
        part_index   <= idx_final;
        samples_left <= left_next;
      end
      if (!aborting && opening) begin
        latched_param <= param_r;
        latched_raw   <= raw_r;
      end
    end
  end

endmodule

### rtl/core/prp_chunker.sv
// Splits each coded sample into chunks of at most one word of bits, in stream order.
// Holds the sample being split and a registered chunk for the packer.
// Depends on prp_pkg.
module prp_chunker #(
  parameter int MAX_QUOTIENT = 1023,
  localparam int QuotW = $clog2(MAX_QUOTIENT + 1),
  localparam int RemW  = QuotW + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                desc_valid,
  input  prp_pkg::desc_t      desc,
  input  logic [QuotW-1:0]    desc_zeros,
  output logic                desc_ready,
  output logic                chunk_valid,
  output prp_pkg::chunk_t     chunk,
  input  logic                chunk_take
);

  logic                               held;
  prp_pkg::desc_t                     cur;
  logic [QuotW-1:0]                   zeros_left;

  logic                               slot_free;
  logic                               emit;
  logic [RemW-1:0]                    rem_total;
  logic                               last;
  logic [prp_pkg::WORD_CNT_W-1:0]     n;
  logic [prp_pkg::WORD_BITS-1:0]      head_part;
  logic [RemW-1:0]                    tail_off;
  logic                               tail_on;
  logic [prp_pkg::WORD_CNT_W-1:0]     tail_cnt;
  logic [prp_pkg::WORD_BITS-1:0]      tail_part;
  logic [prp_pkg::WORD_CNT_W-1:0]     after_head;
  logic [QuotW-1:0]                   zero_used;
  logic [prp_pkg::WORD_CNT_W-1:0]     after_zero;
  logic [prp_pkg::TAIL_CNT_W-1:0]     tail_len_next;

  assign slot_free  = !chunk_valid || chunk_take;
  assign emit       = held && slot_free;
  assign desc_ready = !held || (slot_free && last);

  always_comb begin
    rem_total = RemW'(cur.head_len) + RemW'(zeros_left) + RemW'(cur.tail_len);
    last      = rem_total <= RemW'(prp_pkg::WORD_BITS);
    n         = last ? rem_total[prp_pkg::WORD_CNT_W-1:0]
                     : prp_pkg::WORD_CNT_W'(prp_pkg::WORD_BITS);
    after_head = n - prp_pkg::WORD_CNT_W'(cur.head_len);
    head_part  = prp_pkg::WORD_BITS'(cur.head) << after_head;
    tail_off   = RemW'(cur.head_len) + RemW'(zeros_left);
    tail_on    = tail_off < RemW'(n);
    tail_cnt   = n - tail_off[prp_pkg::WORD_CNT_W-1:0];
    tail_part  = tail_on ? (cur.tail >> (cur.tail_len - tail_cnt)) : '0;
    zero_used  = (zeros_left < QuotW'(after_head)) ? zeros_left : QuotW'(after_head);
    after_zero = after_head - prp_pkg::WORD_CNT_W'(zero_used);
    tail_len_next = cur.tail_len - after_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (desc_ready) begin
      held <= desc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_ready) begin
      if (desc_valid) begin
        cur        <= desc;
        zeros_left <= desc_zeros;
      end
    end else if (emit) begin
      cur.head     <= '0;
      cur.head_len <= '0;
      zeros_left   <= zeros_left - zero_used;
      cur.tail_len <= tail_len_next;
      cur.tail     <= cur.tail & ~({prp_pkg::TAIL_BITS{1'b1}} << tail_len_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_valid <= 1'b0;
    end else if (slot_free) begin
      chunk_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      chunk.data      <= head_part | tail_part;
      chunk.len       <= n;
      chunk.block_end <= cur.block_end && last;
      chunk.abort     <= cur.abort;
      chunk.status    <= cur.status;
    end
  end

endmodule

### rtl/core/prp_packer.sv
// Bit accumulator that packs chunks MSB first into words and drives the result register.
// Handles the end-of-block flush and the abort result.
// Depends on prp_pkg.
module prp_packer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               chunk_valid,
  input  prp_pkg::chunk_t                    chunk,
  output logic                               chunk_take,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [prp_pkg::WORD_BITS-1:0]      word,
  output logic [prp_pkg::WORD_CNT_W-1:0]     valid_bits,
  output logic                               block_end,
  output logic [1:0]                         status
);

  localparam int PairBits = 2 * prp_pkg::WORD_BITS;
  localparam int ShiftW   = $clog2(PairBits + 1);

  logic [prp_pkg::WORD_BITS-1:0]  acc;
  logic [prp_pkg::ACC_CNT_W-1:0]  acc_cnt;
  logic                           flush_pending;
  prp_pkg::status_t               status_r;

  logic                           out_free;
  logic [prp_pkg::WORD_CNT_W-1:0] total;
  logic [ShiftW-1:0]              shift;
  logic [PairBits-1:0]            joined;
  logic                           full;
  logic                           emits;
  logic                           res_load;

  always_comb begin
    total    = prp_pkg::WORD_CNT_W'(acc_cnt) + chunk.len;
    shift    = ShiftW'(PairBits) - ShiftW'(total);
    joined   = {acc, {prp_pkg::WORD_BITS{1'b0}}} | (PairBits'(chunk.data) << shift);
    full     = total >= prp_pkg::WORD_CNT_W'(prp_pkg::WORD_BITS);
    emits    = chunk.abort || chunk.block_end || full;
    out_free = !result_valid || !result_stall;
    chunk_take = chunk_valid && !flush_pending && (out_free || !emits);
    res_load = (flush_pending && out_free) || (chunk_take && emits);
  end

  assign status = status_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      flush_pending <= 1'b0;
      acc           <= '0;
      acc_cnt       <= '0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
      if (flush_pending && out_free) begin
        word          <= acc;
        valid_bits    <= prp_pkg::WORD_CNT_W'(acc_cnt);
        block_end     <= 1'b1;
        status_r      <= prp_pkg::STATUS_OK;
        acc           <= '0;
        acc_cnt       <= '0;
        flush_pending <= 1'b0;
      end else if (chunk_take) begin
        if (chunk.abort) begin
          word         <= '0;
          valid_bits   <= '0;
          block_end    <= 1'b1;
          status_r     <= chunk.status;
          acc          <= '0;
          acc_cnt      <= '0;
        end else if (full) begin
          word          <= joined[PairBits-1:prp_pkg::WORD_BITS];
          valid_bits    <= prp_pkg::WORD_CNT_W'(prp_pkg::WORD_BITS);
          block_end     <= chunk.block_end &&
                           (total == prp_pkg::WORD_CNT_W'(prp_pkg::WORD_BITS));
          status_r      <= prp_pkg::STATUS_OK;
          acc           <= joined[prp_pkg::WORD_BITS-1:0];
          acc_cnt       <= prp_pkg::ACC_CNT_W'(total - prp_pkg::WORD_CNT_W'(prp_pkg::WORD_BITS));
          flush_pending <= chunk.block_end &&
                           (total != prp_pkg::WORD_CNT_W'(prp_pkg::WORD_BITS));
        end else if (chunk.block_end) begin
          word         <= joined[PairBits-1:prp_pkg::WORD_BITS];
          valid_bits   <= total;
          block_end    <= 1'b1;
          status_r     <= prp_pkg::STATUS_OK;
          acc          <= '0;
          acc_cnt      <= '0;
        end else begin
          acc     <= joined[PairBits-1:prp_pkg::WORD_BITS];
          acc_cnt <= prp_pkg::ACC_CNT_W'(total);
        end
      end
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for partitioned_rice_residual_packer_core.
// A scoreboard class predicts the packed words of each accepted sample transaction.
// Depends on prp_pkg and the packer core. Directed cases run first, then random phases.
module tb;

  localparam int MaxQuotient  = 1023;
  localparam int MaxWords     = 40;
  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 16;

  class rice_scoreboard;
    typedef struct {
      logic [31:0]      word;
      logic [5:0]       bits;
      logic             last;
      prp_pkg::status_t st;
    } packed_word_t;

    bit        wide_mode;
    bit [3:0]  part_order;
    bit [5:0]  pred_order;
    bit [15:0] blk_size;
    bit [63:0] acc;
    int        acc_n;
    bit [15:0] part_idx;
    bit [15:0] part_left;
    bit [4:0]  cur_param;
    bit        cur_raw;
    bit        started;
    int        step_n;
    int        errors;
    packed_word_t pending[$];

    function void restart();
      acc = '0;
      acc_n = 0;
      part_idx = '0;
      part_left = '0;
      started = 1'b0;
    endfunction

    function void reset();
      wide_mode = 1'b0;
      part_order = '0;
      pred_order = '0;
      blk_size = 16'd4096;
      cur_param = '0;
      cur_raw = 1'b0;
      errors = 0;
      pending.delete();
      restart();
    endfunction

    function void set_reg(prp_pkg::cfg_index_t idx, bit [15:0] val);
      case (idx)
        prp_pkg::CFG_WIDE_PARAM_MODE: wide_mode = val[0];
        prp_pkg::CFG_PARTITION_ORDER: part_order = val[3:0];
        prp_pkg::CFG_PREDICTOR_ORDER: pred_order = val[5:0];
        prp_pkg::CFG_BLOCK_SIZE:      blk_size = val;
        default: ;
      endcase
    endfunction

    function bit opening();
      return !started || part_left == 0;
    endfunction

    function void emit(bit [31:0] w, int n, bit last, prp_pkg::status_t st);
      packed_word_t e;
      if (step_n < MaxWords) begin
        e.word = w;
        e.bits = n[5:0];
        e.last = last;
        e.st = st;
        pending.push_back(e);
      end
      step_n++;
    endfunction

    function void push_bit(bit b);
      acc = {acc[62:0], b};
      acc_n++;
      if (acc_n >= 32) begin
        emit(acc[31:0], 32, 1'b0, prp_pkg::STATUS_OK);
        acc = '0;
        acc_n = 0;
      end
    endfunction

    function void push_bits(bit [31:0] v, int n);
      for (int i = n; i > 0; i--) push_bit(v[i-1]);
    endfunction

    function void abort(prp_pkg::status_t st);
      restart();
      emit('0, 0, 1'b1, st);
    endfunction

    function int part_len(int idx);
      int base;
      base = blk_size >> part_order;
      if (idx == 0) return (base > pred_order) ? base - pred_order : 0;
      return base;
    endfunction

    function void part_header();
      int plen;
      plen = wide_mode ? 5 : 4;
      if (cur_raw) begin
        push_bits((32'd1 << plen) - 32'd1, plen);
        push_bits(32'(cur_param), 5);
      end else begin
        push_bits(32'(cur_param), plen);
      end
    endfunction

    function void open_part(bit [4:0] p, bit r);
      int len;
      cur_param = p;
      cur_raw = r;
      part_header();
      len = part_len(part_idx);
      // An empty first partition still gets its header; the next one opens with this sample.
      if (len == 0 && part_idx == 0 && part_order != 0) begin
        part_idx = 16'd1;
        part_header();
        len = part_len(1);
      end
      if (len == 0) len = 1;
      part_left = len[15:0];
    endfunction

    function void note_item(bit [31:0] x, bit [4:0] p, bit r);
      int        esc;
      int        base;
      bit        open_now;
      bit [4:0]  k;
      bit        use_raw;
      bit [31:0] u;
      bit [31:0] q;
      bit [63:0] sh;
      esc = wide_mode ? 31 : 15;
      base = blk_size >> part_order;
      open_now = opening();
      step_n = 0;
      u = '0;
      if (!started && (base < pred_order || (base << part_order) == pred_order)) begin
        abort(prp_pkg::STATUS_ORDER);
        return;
      end
      k = open_now ? p : cur_param;
      use_raw = open_now ? r : cur_raw;
      if (open_now && !use_raw && k >= esc) begin
        abort(prp_pkg::STATUS_ESCAPE);
        return;
      end
      if (!use_raw) begin
        u = x[31] ? {~x[30:0], 1'b1} : {x[30:0], 1'b0};
        if ((u >> k) > MaxQuotient) begin
          abort(prp_pkg::STATUS_QUOTIENT);
          return;
        end
      end
      if (!started) begin
        push_bits(32'(wide_mode), 2);
        push_bits(32'(part_order), 4);
        started = 1'b1;
        part_idx = '0;
        open_part(p, r);
      end else if (part_left == 0) begin
        part_idx = part_idx + 16'd1;
        open_part(p, r);
      end
      if (use_raw) begin
        push_bits(x & ((32'd1 << k) - 32'd1), k);
      end else begin
        q = u >> k;
        repeat (q) push_bit(1'b0);
        push_bit(1'b1);
        push_bits(u & ((32'd1 << k) - 32'd1), k);
      end
      part_left = part_left - 16'd1;
      if (part_left == 0 && int'(part_idx) >= (1 << part_order) - 1) begin
        if (acc_n > 0) begin
          sh = acc << (32 - acc_n);
          emit(sh[31:0], acc_n, 1'b1, prp_pkg::STATUS_OK);
        end else if (step_n > 0) begin
          pending[pending.size()-1].last = 1'b1;
        end else begin
          emit('0, 0, 1'b1, prp_pkg::STATUS_OK);
        end
        restart();
      end
    endfunction

    function void check_word(logic [31:0] w, logic [5:0] n, logic last, logic [1:0] st);
      packed_word_t e;
      if (pending.size() == 0) begin
        $error("result transaction with nothing expected: word %h", w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (w !== e.word) begin
        $error("word: expected %h, got %h", e.word, w);
        errors++;
      end
      if (n !== e.bits) begin
        $error("valid_bits: expected %0d, got %0d", e.bits, n);
        errors++;
      end
      if (last !== e.last) begin
        $error("block_end: expected %0d, got %0d", e.last, last);
        errors++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [prp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [prp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            item_valid = 1'b0;
  logic                            item_stall;
  logic signed [31:0]              residual = '0;
  logic [4:0]                      rice_param = '0;
  logic                            raw_escape = 1'b0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  logic [prp_pkg::WORD_BITS-1:0]   word;
  logic [prp_pkg::WORD_CNT_W-1:0]  valid_bits;
  logic                            block_end;
  logic [1:0]                      status;
  bit                              idle_on = 1'b1;
  int                              quiet_cycles = 0;
  rice_scoreboard                  sb;

  partitioned_rice_residual_packer_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_word(word, valid_bits, block_end, status);
    end
    result_stall <= idle_on && ($urandom_range(99) < 23);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(bit [31:0] x, bit [4:0] p, bit r);
    while (idle_on && $urandom_range(99) < 23) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    residual <= x;
    rice_param <= p;
    raw_escape <= r;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(x, p, r);
  endtask

  task automatic wait_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // A sample transaction that yields no word may still be in flight; let it drain.
  task automatic settle();
    wait_results();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(prp_pkg::cfg_index_t idx, bit [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(bit mode, bit [3:0] po, bit [5:0] pred, bit [15:0] bs);
    write_reg(prp_pkg::CFG_WIDE_PARAM_MODE, 16'(mode));
    write_reg(prp_pkg::CFG_PARTITION_ORDER, 16'(po));
    write_reg(prp_pkg::CFG_PREDICTOR_ORDER, 16'(pred));
    write_reg(prp_pkg::CFG_BLOCK_SIZE, bs);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    bit [31:0] x;
    bit [4:0]  p;
    bit        r;
    bit [4:0]  eff_k;
    bit        eff_raw;
    int        nb;
    int        esc;
    bit        mode;
    bit [3:0]  po;
    bit [5:0]  pred;
    bit [15:0] bs;
    int        base;
    sb = new();
    sb.reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Long unary runs up to the quotient limit, then the quotient and escape abort causes.
    configure(1'b0, 4'd0, 6'd0, 16'd4);
    send_item(32'd0, 5'd0, 1'b0);
    send_item(32'h0000_01ff, 5'd0, 1'b0);
    send_item(32'hffff_fe00, 5'd0, 1'b0);
    send_item(32'h0000_0200, 5'd0, 1'b0);
    send_item(32'h8000_0000, 5'd0, 1'b0);
    send_item(32'd7, 5'd15, 1'b0);
    send_item(32'h8000_0000, 5'd31, 1'b1);
    send_item(32'h7fff_ffff, 5'd0, 1'b0);
    send_item(32'hffff_ffff, 5'd5, 1'b1);
    send_item(32'h1234_5678, 5'd0, 1'b0);

    // Empty first partition in five-bit mode, then a parameter of 31 rejected as the five-bit escape code.
    settle();
    configure(1'b1, 4'd1, 6'd4, 16'd8);
    send_item(32'd3, 5'd30, 1'b0);
    send_item(32'hffff_fffb, 5'd1, 1'b0);
    send_item(32'd100, 5'd2, 1'b1);
    send_item(32'h8000_0000, 5'd3, 1'b0);
    send_item(32'd0, 5'd31, 1'b0);

    // A block with no residual samples, predictor order above block size, then partition order too large.
    settle();
    configure(1'b0, 4'd0, 6'd4, 16'd4);
    send_item(32'd1, 5'd1, 1'b0);
    settle();
    write_reg(prp_pkg::CFG_PREDICTOR_ORDER, 16'd5);
    cfg_wr_en <= 1'b0;
    send_item(32'd1, 5'd1, 1'b0);
    settle();
    configure(1'b0, 4'd15, 6'd0, 16'd4096);
    send_item(32'd1, 5'd1, 1'b0);

    // Block ends on a word boundary, with the final sample adding no bits.
    settle();
    configure(1'b0, 4'd1, 6'd0, 16'd4);
    send_item(32'd0, 5'd5, 1'b0);
    send_item(32'd16, 5'd5, 1'b0);
    send_item(32'd9, 5'd0, 1'b1);
    send_item(32'd9, 5'd0, 1'b1);

    // Single-sample block whose bits fill exactly one word.
    settle();
    configure(1'b1, 4'd0, 6'd0, 16'd1);
    send_item(32'd5, 5'd20, 1'b0);

    // A wide parameter stays latched after switching back to four-bit mode.
    settle();
    configure(1'b1, 4'd0, 6'd0, 16'd6);
    send_item(32'd3, 5'd20, 1'b0);
    settle();
    write_reg(prp_pkg::CFG_WIDE_PARAM_MODE, 16'd0);
    cfg_wr_en <= 1'b0;
    send_item(32'hffff_fff9, 5'd9, 1'b0);

    settle();
    configure(1'b0, 4'd0, 6'd32, 16'hffff);
    send_item(32'hffff_ffff, 5'd3, 1'b0);

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      idle_on <= (ph != 4);
      if (ph == 6) begin
        configure(1'b0, 4'd15, 6'd0, 16'hffff);
      end else if (ph == 8) begin
        configure(1'b1, 4'd0, 6'd32, 16'hffff);
      end else if (ph == 2) begin
        write_reg(prp_pkg::CFG_WIDE_PARAM_MODE, 16'(!sb.wide_mode));
        cfg_wr_en <= 1'b0;
      end else if (ph == 5) begin
        write_reg(prp_pkg::CFG_PARTITION_ORDER, 16'($urandom_range(3)));
        cfg_wr_en <= 1'b0;
      end else begin
        mode = $urandom_range(1);
        po = $urandom_range(3);
        bs = $urandom_range(1, 48);
        base = bs >> po;
        if (base > 0 && $urandom_range(3) != 0) begin
          pred = $urandom_range(0, (base - 1 > 32) ? 32 : base - 1);
        end else begin
          pred = $urandom_range(0, 32);
        end
        configure(mode, po, pred, bs);
      end

      for (int n = 0; n < 20; n++) begin
        if (ph == 3 && n == 11) wait_results();
        esc = sb.wide_mode ? 31 : 15;
        if (sb.opening()) begin
          if ($urandom_range(99) < 15) begin
            eff_raw = 1'b1;
            eff_k = $urandom_range(0, 31);
          end else if ($urandom_range(99) < 5) begin
            eff_raw = 1'b0;
            eff_k = $urandom_range(esc, 31);
          end else begin
            eff_raw = 1'b0;
            eff_k = ($urandom_range(3) == 0) ? $urandom_range(0, esc - 1) : $urandom_range(0, 8);
          end
          p = eff_k;
          r = eff_raw;
        end else begin
          eff_k = sb.cur_param;
          eff_raw = sb.cur_raw;
          p = $urandom_range(1) ? eff_k : 5'($urandom);
          r = $urandom_range(1) ? eff_raw : 1'($urandom);
        end
        if (eff_raw || $urandom_range(99) < 5) begin
          x = $urandom;
        end else begin
          nb = eff_k + $urandom_range(0, 5);
          if (nb > 31) nb = 31;
          x = $urandom & ((32'd1 << nb) - 32'd1);
          if ($urandom_range(1)) x = ~x;
        end
        send_item(x, p, r);
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
